@@ hw/rtl/its_pkg.sv @@
// its_pkg: shared types, constants and the day-of-year table of the
// timestamp to epoch converter. Depends on nothing.
`default_nettype none

package its_pkg;

  localparam int NUM_ACC    = 6;
  localparam int ACC_W      = 14;
  localparam int POS_W      = 5;
  localparam int MIN_LENGTH = 19;
  localparam int EPOCH_W    = 40;

  localparam logic [ACC_W-1:0] ACC_MAX = 14'd9999;
  localparam logic [POS_W-1:0] POS_MAX = 5'd31;

  // character offsets of year, month, day, hour, minute, second
  localparam logic [POS_W-1:0] ACC_START [NUM_ACC] = '{5'd0, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17};

  localparam int ACC_YEAR   = 0;
  localparam int ACC_MONTH  = 1;
  localparam int ACC_DAY    = 2;
  localparam int ACC_HOUR   = 3;
  localparam int ACC_MINUTE = 4;
  localparam int ACC_SECOND = 5;

  typedef struct packed {
    logic [ACC_W-1:0] year;
    logic [ACC_W-1:0] month;
    logic [ACC_W-1:0] day;
    logic [ACC_W-1:0] hour;
    logic [ACC_W-1:0] minute;
    logic [ACC_W-1:0] second;
    logic             too_short;
  } its_date_t;

  // days before the first of a month, counted from march (mp = 0 is march)
  function automatic logic [8:0] doy_of(logic [3:0] mp);
    logic [8:0] res;
    case (mp)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/its_char_if.sv @@
// its_char_if: input channel, one timestamp character per request.
// Depends on nothing.
`default_nettype none

interface its_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       final_char;

  modport source (output valid, output character, output final_char, input ready);
  modport sink   (input valid, input character, input final_char, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/its_epoch_if.sv @@
// its_epoch_if: result channel, one epoch value per request.
// Depends on nothing.
`default_nettype none

interface its_epoch_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] epoch_seconds;
  logic               too_short;

  modport source (output valid, output epoch_seconds, output too_short, input ready);
  modport sink   (input valid, input epoch_seconds, input too_short, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/its_parser.sv @@
// its_parser: character position, six digit accumulators and the date record
// register loaded on the final character. Depends on its_pkg, its_char_if.
`default_nettype none

module its_parser
  import its_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  its_char_if.sink   in_i,
  output its_date_t  rec_o,
  output logic       rec_valid_o,
  input  wire logic  rec_ready_i
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [ACC_W-1:0] acc_q [NUM_ACC];
  logic [ACC_W-1:0] acc_upd [NUM_ACC];
  logic [NUM_ACC-1:0] act_q, act_upd;
  logic             rec_v_q;
  its_date_t        rec_q;
  logic             in_acc;
  logic             is_digit;
  logic [3:0]       digit;
  logic [POS_W:0]   len;
  logic             short_len;

  assign in_i.ready = !rec_v_q || rec_ready_i;
  assign in_acc     = in_i.valid && in_i.ready;

  assign is_digit = (in_i.character >= 8'd48) && (in_i.character <= 8'd57);
  assign digit    = is_digit ? 4'(in_i.character - 8'd48) : 4'd0;

  always_comb begin
    logic [17:0] v;
    for (int i = 0; i < NUM_ACC; i++) begin
      v          = 18'(acc_q[i]) * 18'd10 + 18'(digit);
      acc_upd[i] = acc_q[i];
      act_upd[i] = act_q[i];
      if (pos_q == ACC_START[i]) begin
        acc_upd[i] = ACC_W'(digit);
        act_upd[i] = is_digit;
      end else if (pos_q > ACC_START[i] && act_q[i]) begin
        if (is_digit) begin
          acc_upd[i] = (v > 18'(ACC_MAX)) ? ACC_MAX : v[ACC_W-1:0];
        end else begin
          act_upd[i] = 1'b0;
        end
      end
    end
  end

  assign len       = {1'b0, pos_q} + 6'd1;
  assign pos_d     = (pos_q == POS_MAX) ? POS_MAX : len[POS_W-1:0];
  assign short_len = len < 6'(MIN_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      act_q   <= '0;
      rec_v_q <= 1'b0;
      for (int i = 0; i < NUM_ACC; i++) acc_q[i] <= '0;
    end else begin
      if (in_acc) begin
        if (in_i.final_char) begin
          pos_q <= '0;
          act_q <= '0;
          for (int i = 0; i < NUM_ACC; i++) acc_q[i] <= '0;
        end else begin
          pos_q <= pos_d;
          act_q <= act_upd;
          for (int i = 0; i < NUM_ACC; i++) acc_q[i] <= acc_upd[i];
        end
      end
      if (in_acc && in_i.final_char) begin
        rec_v_q <= 1'b1;
      end else if (rec_ready_i) begin
        rec_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.final_char) begin
      rec_q.year      <= acc_upd[ACC_YEAR];
      rec_q.month     <= acc_upd[ACC_MONTH];
      rec_q.day       <= acc_upd[ACC_DAY];
      rec_q.hour      <= acc_upd[ACC_HOUR];
      rec_q.minute    <= acc_upd[ACC_MINUTE];
      rec_q.second    <= acc_upd[ACC_SECOND];
      rec_q.too_short <= short_len;
    end
  end

  assign rec_o       = rec_q;
  assign rec_valid_o = rec_v_q;

`ifndef SYNTH
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.final_char |=> pos_q == '0 && act_q == '0)
    else $error("state not cleared after final character");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_i.final_char && pos_q != POS_MAX |=> pos_q == $past(pos_q) + 5'd1)
    else $error("character position did not advance");

  a_acc_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q[0] <= ACC_MAX && acc_q[1] <= ACC_MAX && acc_q[2] <= ACC_MAX &&
    acc_q[3] <= ACC_MAX && acc_q[4] <= ACC_MAX && acc_q[5] <= ACC_MAX)
    else $error("accumulator above saturation limit");

  a_rec_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rec_v_q) |-> $past(in_acc && in_i.final_char))
    else $error("date record without final character");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/its_convert.sv @@
// its_convert: eight-stage pipeline from a date record to epoch seconds,
// ending in the result register. Depends on its_pkg, its_epoch_if.
`default_nettype none

module its_convert
  import its_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  its_date_t  rec_i,
  input  wire logic  rec_valid_i,
  output logic       rec_ready_o,
  its_epoch_if.source out_o
);

  localparam int NumStages = 8;

  typedef struct packed {
    logic             mzero;
    logic [ACC_W-1:0] x;
    logic [9:0]       q;
    logic [ACC_W-1:0] y;
    logic [ACC_W-1:0] d;
    logic [25:0]      hp;
    logic [19:0]      ms;
    logic             too_short;
  } st1_t;

  typedef struct packed {
    logic [14:0]      yy;
    logic [3:0]       mp;
    logic [ACC_W-1:0] d;
    logic [25:0]      hms;
    logic             too_short;
  } st2_t;

  typedef struct packed {
    logic [14:0]      yy;
    logic [5:0]       era;
    logic [8:0]       doy;
    logic [ACC_W-1:0] d;
    logic [25:0]      hms;
    logic             too_short;
  } st3_t;

  typedef struct packed {
    logic [8:0]       yoe;
    logic [5:0]       era;
    logic [8:0]       doy;
    logic [ACC_W-1:0] d;
    logic [25:0]      hms;
    logic             too_short;
  } st4_t;

  typedef struct packed {
    logic [17:0]      doe;
    logic [5:0]       era;
    logic [ACC_W-1:0] d;
    logic [25:0]      hms;
    logic             too_short;
  } st5_t;

  typedef struct packed {
    logic [23:0] days;
    logic [25:0] hms;
    logic        too_short;
  } st6_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] prod;
    logic [25:0]        hms;
    logic               too_short;
  } st7_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic               too_short;
  } st8_t;

  logic [NumStages-1:0] v_q, rdy, vin, ld;
  st1_t st1_q, st1_d;
  st2_t st2_q, st2_d;
  st3_t st3_q, st3_d;
  st4_t st4_q, st4_d;
  st5_t st5_q, st5_d;
  st6_t st6_q, st6_d;
  st7_t st7_q, st7_d;
  st8_t st8_q, st8_d;

  // bubble-collapsing ready chain
  always_comb begin
    rdy[NumStages-1] = !v_q[NumStages-1] || out_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign vin         = {v_q[NumStages-2:0], rec_valid_i};
  assign ld          = rdy & vin;
  assign rec_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (rdy[k]) v_q[k] <= vin[k];
      end
    end
  end

  // month - 1 split into year carry and month index; x / 12 by reciprocal
  always_comb begin
    logic [30:0] qprod;
    st1_d.mzero     = rec_i.month == '0;
    st1_d.x         = rec_i.month - 14'd1;
    qprod           = 31'(st1_d.x) * 31'd43691;
    st1_d.q         = qprod[28:19];
    st1_d.y         = rec_i.year;
    st1_d.d         = rec_i.day;
    st1_d.hp        = 26'(rec_i.hour) * 26'd3600;
    st1_d.ms        = 20'(rec_i.minute) * 20'd60 + 20'(rec_i.second);
    st1_d.too_short = rec_i.too_short;
  end

  // month zero is december of the previous year
  always_comb begin
    logic [ACC_W-1:0] r14;
    logic [3:0]       r;
    logic             low;
    r14   = st1_q.x - 14'(st1_q.q) * 14'd12;
    r     = st1_q.mzero ? 4'd11 : r14[3:0];
    low   = !st1_q.mzero && (r <= 4'd1);
    st2_d.yy = 15'($signed({1'b0, st1_q.y})
             + (st1_q.mzero ? -15'sd1 : $signed({5'b0, st1_q.q}))
             - (low ? 15'sd1 : 15'sd0));
    st2_d.mp        = (r >= 4'd2) ? r - 4'd2 : r + 4'd10;
    st2_d.d         = st1_q.d;
    st2_d.hms       = st1_q.hp + 26'(st1_q.ms);
    st2_d.too_short = st1_q.too_short;
  end

  // era = floor(yy / 400); yy never drops below -1
  always_comb begin
    logic [26:0] eprod;
    eprod = 27'(st2_q.yy[13:0]) * 27'd5243;
    st3_d.era       = st2_q.yy[14] ? 6'b111111 : {1'b0, eprod[25:21]};
    st3_d.yy        = st2_q.yy;
    st3_d.doy       = doy_of(st2_q.mp);
    st3_d.d         = st2_q.d;
    st3_d.hms       = st2_q.hms;
    st3_d.too_short = st2_q.too_short;
  end

  always_comb begin
    logic [14:0] yoe15;
    yoe15 = 15'($signed(st3_q.yy) - $signed({{9{st3_q.era[5]}}, st3_q.era}) * 15'sd400);
    st4_d.yoe       = yoe15[8:0];
    st4_d.era       = st3_q.era;
    st4_d.doy       = st3_q.doy;
    st4_d.d         = st3_q.d;
    st4_d.hms       = st3_q.hms;
    st4_d.too_short = st3_q.too_short;
  end

  always_comb begin
    logic [14:0] cprod;
    cprod = 15'(st4_q.yoe) * 15'd41;
    st5_d.doe = 18'(st4_q.yoe) * 18'd365 + 18'(st4_q.yoe[8:2]) + 18'(st4_q.doy)
              - 18'(cprod[13:12]);
    st5_d.era       = st4_q.era;
    st5_d.d         = st4_q.d;
    st5_d.hms       = st4_q.hms;
    st5_d.too_short = st4_q.too_short;
  end

  always_comb begin
    st6_d.days = 24'($signed({{18{st5_q.era[5]}}, st5_q.era}) * 24'sd146097
               + $signed({6'b0, st5_q.doe}) + $signed({10'b0, st5_q.d})
               - 24'sd719469);
    st6_d.hms       = st5_q.hms;
    st6_d.too_short = st5_q.too_short;
  end

  always_comb begin
    st7_d.prod      = EPOCH_W'($signed({{16{st6_q.days[23]}}, st6_q.days}) * 40'sd86400);
    st7_d.hms       = st6_q.hms;
    st7_d.too_short = st6_q.too_short;
  end

  always_comb begin
    st8_d.epoch     = st7_q.too_short ? '0 : st7_q.prod + {14'b0, st7_q.hms};
    st8_d.too_short = st7_q.too_short;
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) st1_q <= st1_d;
    if (ld[1]) st2_q <= st2_d;
    if (ld[2]) st3_q <= st3_d;
    if (ld[3]) st4_q <= st4_d;
    if (ld[4]) st5_q <= st5_d;
    if (ld[5]) st6_q <= st6_d;
    if (ld[6]) st7_q <= st7_d;
    if (ld[7]) st8_q <= st8_d;
  end

  assign out_o.valid         = v_q[NumStages-1];
  assign out_o.epoch_seconds = $signed(st8_q.epoch);
  assign out_o.too_short     = st8_q.too_short;

`ifndef SYNTH
  a_carry_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |-> st1_q.q <= 10'd833)
    else $error("month carry out of range");

  a_year_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> $signed(st2_q.yy) >= -15'sd1 && st2_q.mp <= 4'd11)
    else $error("shifted year or month index out of range");

  a_yoe_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> st4_q.yoe < 9'd400)
    else $error("year of era out of range");

  a_doe_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] |-> st5_q.doe < 18'd146097)
    else $error("day of era out of range");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/iso_timestamp_to_epoch_seconds_top.sv @@
// Timestamp string to epoch seconds: one character per cycle, sustained.
// A result reaches the output register after its final character is accepted,
// passing the date record register and the eight-stage conversion pipeline.
// Throughput is one character per cycle; a full output only stalls the input
// once the date record register and every pipeline stage hold a result.
// Asynchronous active-low reset clears position, accumulators and all valids.
`default_nettype none

module iso_timestamp_to_epoch_seconds_top
  import its_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  its_char_if.sink    in_i,
  its_epoch_if.source out_o
);

  its_date_t rec;
  logic      rec_valid;
  logic      rec_ready;

  its_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .rec_o       (rec),
    .rec_valid_o (rec_valid),
    .rec_ready_i (rec_ready)
  );

  its_convert u_convert (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (rec),
    .rec_valid_i (rec_valid),
    .rec_ready_o (rec_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
